>>> sv/bmhq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary min-heap queue
// Sizes, request and status codes, entry type and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = ADDR_W + 2;
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        logic ins_load;
        logic del_issue;
        logic del_load;
        logic rd_parent;
        logic rd_child;
        logic up_step;
        logic dn_step;
        logic place;
        logic fail_full;
        logic fail_empty;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic up_swap;
        logic has_left;
        logic dn_swap;
    } stat_t;

endpackage
`default_nettype wire

>>> sv/bmhq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_datapath: heap storage, sift registers and result registers
// One write port and two registered read ports on the heap memory; the
// entry being sifted is held in a register and written once it settles.
// ----------------------------------------------------------------------------
module bmhq_datapath (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bmhq_pkg::cmd_t               cmd,
    output bmhq_pkg::stat_t                   stat,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0] s_priority_req,
    input  wire logic [bmhq_pkg::TAG_W-1:0]   s_item_tag,
    output logic signed [bmhq_pkg::KEY_W-1:0] m_out_priority,
    output logic [bmhq_pkg::TAG_W-1:0]        m_out_tag,
    output logic [bmhq_pkg::STAT_W-1:0]       m_status,
    output logic [bmhq_pkg::OCC_W-1:0]        m_occupancy
);

    bmhq_pkg::entry_t heap_mem [bmhq_pkg::DEPTH];
    bmhq_pkg::entry_t rd_a_reg, rd_b_reg, mov_reg, res_reg;
    logic [bmhq_pkg::STAT_W-1:0] res_stat_reg;
    logic [bmhq_pkg::ADDR_W-1:0] pos_reg;
    logic [bmhq_pkg::CNT_W-1:0]  cnt_reg;

    logic [bmhq_pkg::ADDR_W-1:0] parent_idx, rd_a_addr, rd_b_addr, last_idx;
    logic [bmhq_pkg::IDX_W-1:0]  left_idx, right_idx, cnt_ext, pick_idx;
    logic                        has_right, pick_right, wr_en;
    bmhq_pkg::entry_t            pick_ent, wr_data;

    assign parent_idx = (pos_reg - bmhq_pkg::ADDR_W'(1)) >> 1;
    assign left_idx   = bmhq_pkg::IDX_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + bmhq_pkg::IDX_W'(1);
    assign cnt_ext    = bmhq_pkg::IDX_W'(cnt_reg);
    assign has_right  = right_idx < cnt_ext;
    assign last_idx   = bmhq_pkg::ADDR_W'(cnt_reg - bmhq_pkg::CNT_W'(1));

    assign pick_right = has_right && (rd_a_reg.key > rd_b_reg.key);
    assign pick_ent   = pick_right ? rd_b_reg : rd_a_reg;
    assign pick_idx   = pick_right ? right_idx : left_idx;

    assign stat.full     = cnt_reg >= bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH);
    assign stat.empty    = cnt_reg == '0;
    assign stat.at_root  = pos_reg == '0;
    assign stat.up_swap  = rd_a_reg.key > mov_reg.key;
    assign stat.has_left = left_idx < cnt_ext;
    assign stat.dn_swap  = mov_reg.key > pick_ent.key;

    always_comb begin
        if (cmd.del_issue) begin
            rd_a_addr = '0;
            rd_b_addr = last_idx;
        end else if (cmd.rd_parent) begin
            rd_a_addr = parent_idx;
            rd_b_addr = parent_idx;
        end else begin
            rd_a_addr = left_idx[bmhq_pkg::ADDR_W-1:0];
            rd_b_addr = right_idx[bmhq_pkg::ADDR_W-1:0];
        end
        wr_en = cmd.up_step | cmd.dn_step | cmd.place;
        if (cmd.up_step) begin
            wr_data = rd_a_reg;
        end else if (cmd.dn_step) begin
            wr_data = pick_ent;
        end else begin
            wr_data = mov_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            heap_mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_a_addr];
        rd_b_reg <= heap_mem[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.ins_load) begin
            cnt_reg <= cnt_reg + bmhq_pkg::CNT_W'(1);
        end else if (cmd.del_load) begin
            cnt_reg <= cnt_reg - bmhq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_load) begin
            pos_reg      <= cnt_reg[bmhq_pkg::ADDR_W-1:0];
            mov_reg.key  <= s_priority_req;
            mov_reg.tag  <= s_item_tag;
            res_reg      <= '0;
            res_stat_reg <= bmhq_pkg::STAT_OK;
        end else if (cmd.fail_full) begin
            res_reg      <= '0;
            res_stat_reg <= bmhq_pkg::STAT_FULL;
        end else if (cmd.fail_empty) begin
            res_reg      <= '0;
            res_stat_reg <= bmhq_pkg::STAT_EMPTY;
        end else if (cmd.del_issue) begin
            res_stat_reg <= bmhq_pkg::STAT_OK;
        end else if (cmd.del_load) begin
            res_reg <= rd_a_reg;
            mov_reg <= rd_b_reg;
            pos_reg <= '0;
        end else if (cmd.up_step) begin
            pos_reg <= parent_idx;
        end else if (cmd.dn_step) begin
            pos_reg <= pick_idx[bmhq_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_priority <= res_reg.key;
            m_out_tag      <= res_reg.tag;
            m_status       <= res_stat_reg;
            m_occupancy    <= bmhq_pkg::OCC_W'(cnt_reg);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::DEPTH))
        else $error("entry count above depth");

    a_ins_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_load |=> cnt_reg == $past(cnt_reg) + bmhq_pkg::CNT_W'(1))
        else $error("insert did not bump entry count");

    a_up_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.up_step |=> pos_reg < $past(pos_reg))
        else $error("sift-up did not move toward root");

    a_dn_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.dn_step |=> pos_reg > $past(pos_reg))
        else $error("sift-down did not move toward leaves");

endmodule
`default_nettype wire

>>> sv/bmhq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_ctrl: request sequencer for the binary min-heap queue
// Walks one request through its sift, then hands the result to the
// output register once that register is free.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_req_type,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire bmhq_pkg::stat_t stat,
    output bmhq_pkg::cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_UP_CHK  = 3'd1;
    localparam logic [2:0] ST_UP_CMP  = 3'd2;
    localparam logic [2:0] ST_DN_LOAD = 3'd3;
    localparam logic [2:0] ST_DN_CHK  = 3'd4;
    localparam logic [2:0] ST_DN_CMP  = 3'd5;
    localparam logic [2:0] ST_FINISH  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == bmhq_pkg::REQ_INSERT) begin
                        if (stat.full) begin
                            cmd.fail_full = 1'b1;
                            state_next    = ST_FINISH;
                        end else begin
                            cmd.ins_load = 1'b1;
                            state_next   = ST_UP_CHK;
                        end
                    end else begin
                        if (stat.empty) begin
                            cmd.fail_empty = 1'b1;
                            state_next     = ST_FINISH;
                        end else begin
                            cmd.del_issue = 1'b1;
                            state_next    = ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_CHK: begin
                if (stat.at_root) begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (stat.up_swap) begin
                    cmd.up_step = 1'b1;
                    state_next  = ST_UP_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DN_LOAD: begin
                cmd.del_load = 1'b1;
                state_next   = ST_DN_CHK;
            end
            ST_DN_CHK: begin
                if (!stat.has_left) begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_child = 1'b1;
                    state_next   = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (stat.dn_swap) begin
                    cmd.dn_step = 1'b1;
                    state_next  = ST_DN_CHK;
                end else begin
                    cmd.place  = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/binary_min_heap_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue: priority queue on an array-based binary min-heap
// Input channel (s_*): one request per transaction, insert or delete-min.
// Result channel (m_*): exactly one result transaction per request, in order.
// Insert sifts the new entry up toward the root; delete moves the last
// entry to the root and sifts it down toward the leaves. Each level costs
// one registered read of the heap memory and one compare/write, and the
// sequencer returns to idle as the result is registered. One request is
// worked at a time; s_ready is high only between requests.
// A finished result sits in the output register until taken; a new request
// is accepted meanwhile, and its result waits in the sequencer if the
// receiver still stalls the previous one.
// Insert on a full heap and delete on an empty heap leave the heap unchanged
// and report a status code with zero key and tag.
// Reset empties the heap and clears m_valid; memory contents are not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_req_type,
    input  wire logic signed [bmhq_pkg::KEY_W-1:0]   s_priority_req,
    input  wire logic [bmhq_pkg::TAG_W-1:0]          s_item_tag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [bmhq_pkg::KEY_W-1:0]        m_out_priority,
    output logic [bmhq_pkg::TAG_W-1:0]               m_out_tag,
    output logic [bmhq_pkg::STAT_W-1:0]              m_status,
    output logic [bmhq_pkg::OCC_W-1:0]               m_occupancy
);

    bmhq_pkg::cmd_t  cmd;
    bmhq_pkg::stat_t stat;

    bmhq_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bmhq_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_priority_req (s_priority_req),
        .s_item_tag     (s_item_tag),
        .m_out_priority (m_out_priority),
        .m_out_tag      (m_out_tag),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy)
    );

endmodule
`default_nettype wire
